// File: sv/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int NUM_PLANES = 8;
  localparam int AGE_W      = 4;
  localparam int PLANE_W    = 3;
  localparam int CNT_W      = 4;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // plane groups, bit i is plane i
  localparam logic [NUM_PLANES-1:0] X_MASK  = 8'b1100_0011;
  localparam logic [NUM_PLANES-1:0] X1_MASK = 8'b0000_0011;
  localparam logic [NUM_PLANES-1:0] X2_MASK = 8'b1100_0000;
  localparam logic [NUM_PLANES-1:0] U_MASK  = 8'b0001_0100;
  localparam logic [NUM_PLANES-1:0] V_MASK  = 8'b0010_1000;
  localparam logic [NUM_PLANES-1:0] LO_MASK = 8'b0000_1111;

  localparam logic [CNT_W-1:0] LOW_RES_MIN = 4'd4;

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } rhc_op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_X_THR  = 2'd0,
    CFG_UV_THR = 2'd1,
    CFG_WINDOW = 2'd2,
    CFG_SECTOR = 2'd3
  } rhc_cfg_addr_e;

  localparam logic [2:0] X_THR_RST  = 3'd3;
  localparam logic [2:0] UV_THR_RST = 3'd3;
  localparam logic [3:0] WINDOW_RST = 4'd8;
  localparam logic       SECTOR_RST = 1'b0;

  typedef struct packed {
    logic [2:0] x_thr;
    logic [2:0] uv_thr;
    logic [3:0] window_bc;
    logic       road_sector;
  } rhc_cfg_t;

  // first member in the highest bits, so hit_stored lands in bit 0
  typedef struct packed {
    logic [2:0] noise_uv_count;
    logic [2:0] noise_x_count;
    logic [2:0] real_uv_count;
    logic [2:0] real_x_count;
    logic [3:0] real_count;
    logic       low_res;
    logic       mature_ok;
    logic       stereo_ok;
    logic       horizontal_ok;
    logic       coincidence;
    logic       hit_stored;
  } rhc_result_t;

  localparam int RES_W = $bits(rhc_result_t);

  function automatic logic [CNT_W-1:0] popcount(input logic [NUM_PLANES-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: sv/rhc_eval.sv
`timescale 1ns / 1ps

module rhc_eval import rhc_pkg::*; (
  input  logic [NUM_PLANES-1:0]            slot_valid_i,
  input  logic [NUM_PLANES-1:0]            slot_noise_i,
  input  logic [NUM_PLANES-1:0][AGE_W-1:0] slot_age_i,
  input  rhc_cfg_t                         cfg_i,
  input  logic                             hit_stored_i,
  output rhc_result_t                      result_o
);

  logic [NUM_PLANES-1:0] real_hits;
  logic [NUM_PLANES-1:0] noise_hits;
  logic [NUM_PLANES-1:0] age_match;
  logic [CNT_W-1:0]      x_all, uv_all, rx, ruv, nx, nuv, lo_real, hi_real, rtot;
  logic [AGE_W-1:0]      age_limit;
  logic                  hok, sok, mok;

  assign real_hits  = slot_valid_i & ~slot_noise_i;
  assign noise_hits = slot_valid_i & slot_noise_i;
  assign age_limit  = cfg_i.window_bc - AGE_W'(1);

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      age_match[i] = slot_valid_i[i] && (slot_age_i[i] == age_limit);
    end
  end

  assign x_all   = popcount(slot_valid_i & X_MASK);
  assign uv_all  = popcount(slot_valid_i & (U_MASK | V_MASK));
  assign rx      = popcount(real_hits & X_MASK);
  assign ruv     = popcount(real_hits & ~X_MASK);
  assign nx      = popcount(noise_hits & X_MASK);
  assign nuv     = popcount(noise_hits & ~X_MASK);
  assign lo_real = popcount(real_hits & LO_MASK);
  assign hi_real = popcount(real_hits & ~LO_MASK);
  assign rtot    = popcount(real_hits);

  assign hok = (|(slot_valid_i & X1_MASK)) && (|(slot_valid_i & X2_MASK)) &&
               (x_all >= {1'b0, cfg_i.x_thr});
  assign sok = (cfg_i.uv_thr == 3'd0) ||
               ((|(slot_valid_i & U_MASK)) && (|(slot_valid_i & V_MASK)) &&
                (uv_all >= {1'b0, cfg_i.uv_thr}));
  // a zero window has no mature age
  assign mok = (cfg_i.window_bc != 4'd0) && (|age_match);

  always_comb begin
    result_o                = '0;
    result_o.hit_stored     = hit_stored_i;
    result_o.coincidence    = hok && sok && mok;
    result_o.horizontal_ok  = hok;
    result_o.stereo_ok      = sok;
    result_o.mature_ok      = mok;
    result_o.low_res        = (lo_real < LOW_RES_MIN) || (hi_real < LOW_RES_MIN);
    result_o.real_count     = rtot;
    result_o.real_x_count   = rx[2:0];
    result_o.real_uv_count  = ruv[2:0];
    result_o.noise_x_count  = nx[2:0];
    result_o.noise_uv_count = nuv[2:0];
  end

endmodule

// File: sv/road_hit_coincidence.sv
`timescale 1ns / 1ps
// result: registered, on the master side in the cycle after its input transfer
// throughput: one item per cycle while results are taken; slot update and
//   checks share one combinational pass ahead of state and result registers
// reset: asynchronous, active low; empties all eight plane slots, drops any
//   pending result and loads the default register values

module road_hit_coincidence import rhc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,

  // input items
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // hit_plane[2:0], hit_sector[3], in_window[4], zero pad [7:5]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode[1:0], hit_is_noise[2]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,

  // result items
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // hit_stored[0], coincidence[1], horizontal_ok[2], stereo_ok[3],
  // mature_ok[4], low_res[5], real_count[9:6], real_x_count[12:10],
  // real_uv_count[15:13], noise_x_count[18:16], noise_uv_count[21:19],
  // zero pad [23:22]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // configuration registers
  rhc_cfg_t cfg_q;

  // per-plane hit slots
  logic [NUM_PLANES-1:0]            slot_valid_q, slot_valid_d;
  logic [NUM_PLANES-1:0]            slot_noise_q, slot_noise_d;
  logic [NUM_PLANES-1:0][AGE_W-1:0] slot_age_q, slot_age_d;

  // result register
  logic        out_valid_q;
  rhc_result_t res_q, res_d;

  logic          in_xfer;
  rhc_op_e       op;
  logic [PLANE_W-1:0] plane;
  logic          hit_noise, hit_sector, hit_in_win;
  logic          stored;
  logic [AGE_W-1:0] age_inc;

  // unpack the input transfer
  assign op         = rhc_op_e'(s_axis_tuser_i[1:0]);
  assign hit_noise  = s_axis_tuser_i[2];
  assign plane      = s_axis_tdata_i[PLANE_W-1:0];
  assign hit_sector = s_axis_tdata_i[3];
  assign hit_in_win = s_axis_tdata_i[4];

  // the result register frees up when its content is taken this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // slot update for the accepted item
  always_comb begin
    slot_valid_d = slot_valid_q;
    slot_noise_d = slot_noise_q;
    slot_age_d   = slot_age_q;
    stored       = 1'b0;
    age_inc      = '0;
    if (in_xfer) begin
      unique case (op)
        OP_HIT: begin
          if (hit_in_win && (hit_sector == cfg_q.road_sector)) begin
            // an empty plane takes the hit; a real hit also replaces noise
            if (!slot_valid_q[plane] || (!hit_noise && slot_noise_q[plane])) begin
              slot_valid_d[plane] = 1'b1;
              slot_noise_d[plane] = hit_noise;
              slot_age_d[plane]   = '0;
              stored              = 1'b1;
            end
          end
        end
        OP_TICK: begin
          // age every stored hit, saturating, and retire it past the window
          for (int i = 0; i < NUM_PLANES; i++) begin
            if (slot_valid_q[i]) begin
              age_inc = (slot_age_q[i] == AGE_MAX) ? slot_age_q[i]
                                                   : slot_age_q[i] + AGE_W'(1);
              slot_age_d[i] = age_inc;
              if (age_inc >= cfg_q.window_bc) begin
                slot_valid_d[i] = 1'b0;
              end
            end
          end
        end
        OP_CLEAR: begin
          slot_valid_d = '0;
          slot_noise_d = '0;
          slot_age_d   = '0;
        end
        default: begin
          // unused code: state stays, checks are still reported
        end
      endcase
    end
  end

  // checks and counts on the updated slots
  rhc_eval u_eval (
    .slot_valid_i (slot_valid_d),
    .slot_noise_i (slot_noise_d),
    .slot_age_i   (slot_age_d),
    .cfg_i        (cfg_q),
    .hit_stored_i (stored),
    .result_o     (res_d)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_thr       <= X_THR_RST;
      cfg_q.uv_thr      <= UV_THR_RST;
      cfg_q.window_bc   <= WINDOW_RST;
      cfg_q.road_sector <= SECTOR_RST;
    end else if (cfg_we_i) begin
      unique case (rhc_cfg_addr_e'(cfg_addr_i))
        CFG_X_THR:  cfg_q.x_thr       <= cfg_wdata_i[2:0];
        CFG_UV_THR: cfg_q.uv_thr      <= cfg_wdata_i[2:0];
        CFG_WINDOW: cfg_q.window_bc   <= cfg_wdata_i[3:0];
        CFG_SECTOR: cfg_q.road_sector <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // slot state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      slot_noise_q <= '0;
      slot_age_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
      slot_noise_q <= slot_noise_d;
      slot_age_q   <= slot_age_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only on an input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - RES_W)'(0), res_q};

endmodule

// File: sv/rhc_checker.sv
`timescale 1ns / 1ps

module rhc_checker import rhc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_USER_W-1:0]  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  rhc_result_t res;
  logic        in_xfer;
  logic        in_clear;
  logic        in_not_hit;

  assign res        = rhc_result_t'(m_axis_tdata_o[RES_W-1:0]);
  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_clear   = in_xfer && (s_axis_tuser_i[1:0] == OP_CLEAR);
  assign in_not_hit = in_xfer && (s_axis_tuser_i[1:0] != OP_HIT);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a clear leaves an empty road
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_clear |=> m_axis_tvalid_o && !res.hit_stored && res.real_count == 4'd0 &&
                 res.noise_x_count == 3'd0 && res.noise_uv_count == 3'd0 &&
                 !res.horizontal_ok && !res.mature_ok && res.low_res)
    else $error("road not empty after clear");

  // only a hit offer can store
  a_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_not_hit |=> m_axis_tvalid_o && !res.hit_stored)
    else $error("hit stored by a non-hit item");

  // combined flag and counts agree
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      res.coincidence == (res.horizontal_ok && res.stereo_ok && res.mature_ok) &&
      res.real_count == ({1'b0, res.real_x_count} + {1'b0, res.real_uv_count}))
    else $error("result fields disagree");

endmodule

bind road_hit_coincidence rhc_checker u_rhc_checker (.*);
